FILE: rtl/core/dlr_pkg.sv
// Shared types and constants for the DDA line rasterizer.
package dlr_pkg;

  localparam int COORD_W         = 6;
  localparam int DIM_W           = 7;
  localparam int INK_W           = 8;
  localparam int CFG_IDX_W       = 2;
  localparam int IN_DATA_W       = 32;
  localparam int OUT_DATA_W      = 24;
  localparam int SCREEN_SIZE_DEF = 64;
  localparam int QUEUE_DEPTH_DEF = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef logic [COORD_W-1:0] coord_t;

  // One classified segment, major axis already chosen and ordered.
  typedef struct packed {
    coord_t             major_start;
    coord_t             major_end;
    coord_t             minor_start;
    coord_t             minor_step;
    coord_t             major_span;
    logic               y_major;
    logic               descending;
    logic [INK_W-1:0]   ink;
  } seg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  typedef struct packed {
    logic busy;
  } back_stat_t;

endpackage

FILE: rtl/core/dlr_front.sv
// Front end: accepts segments and classifies major axis, direction and spans.
module dlr_front (
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [dlr_pkg::IN_DATA_W-1:0] s_tdata,
  input  dlr_pkg::queue_stat_t         q_stat,
  output logic                         push,
  output dlr_pkg::seg_t                seg
);
  import dlr_pkg::*;

  coord_t sx, sy, ex, ey;
  coord_t adx, ady;
  coord_t smaj0, emaj0, smin0, emin0;
  coord_t smaj, emaj, smin, emin;
  logic   ymaj, swap, desc;

  assign sx = s_tdata[5:0];
  assign sy = s_tdata[11:6];
  assign ex = s_tdata[17:12];
  assign ey = s_tdata[23:18];

  always_comb begin
    adx   = (sx > ex) ? sx - ex : ex - sx;
    ady   = (sy > ey) ? sy - ey : ey - sy;
    ymaj  = ady > adx;
    smaj0 = ymaj ? sy : sx;
    emaj0 = ymaj ? ey : ex;
    smin0 = ymaj ? sx : sy;
    emin0 = ymaj ? ex : ey;
    // walk from the endpoint with the smaller major coordinate
    swap  = smaj0 > emaj0;
    smaj  = swap ? emaj0 : smaj0;
    emaj  = swap ? smaj0 : emaj0;
    smin  = swap ? emin0 : smin0;
    emin  = swap ? smin0 : emin0;
    desc  = emin < smin;

    seg.major_start = smaj;
    seg.major_end   = emaj;
    seg.minor_start = smin;
    seg.minor_step  = desc ? smin - emin : emin - smin;
    seg.major_span  = emaj - smaj;
    seg.y_major     = ymaj;
    seg.descending  = desc;
    seg.ink         = s_tdata[31:24];
  end

  assign s_tready = !q_stat.full;
  assign push     = s_tvalid && s_tready;

endmodule

FILE: rtl/core/dlr_queue.sv
// Short segment queue between the front end and the pixel stepper.
module dlr_queue #(
  parameter int DEPTH = dlr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  dlr_pkg::seg_t        wr_seg,
  input  logic                 pop,
  output dlr_pkg::seg_t        rd_seg,
  output dlr_pkg::queue_stat_t stat
);
  import dlr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  seg_t            entries [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_seg     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_seg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/dlr_back.sv
// Back end: steps one classified segment a pixel per cycle into the output register while the output is not stalled.
module dlr_back (
  input  logic                           clk,
  input  logic                           rst,
  input  dlr_pkg::seg_t                  seg,
  input  dlr_pkg::queue_stat_t           q_stat,
  output logic                           pop,
  input  logic [dlr_pkg::DIM_W-1:0]      screen_width,
  input  logic [dlr_pkg::DIM_W-1:0]      screen_height,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [dlr_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tlast,
  output dlr_pkg::back_stat_t            stat
);
  import dlr_pkg::*;

  logic             busy;
  coord_t           major_pos, major_end, minor_base, error_term;
  coord_t           minor_step, major_span;
  logic             y_major, descending;
  logic [INK_W-1:0] ink;

  logic             out_valid;
  coord_t           pixel_x, pixel_y;
  logic [INK_W-1:0] paint;
  logic             in_screen, last_pixel;

  logic             load, adv, at_end, wrap;
  coord_t           minor_cur, px, py, error_term_next;
  logic [COORD_W:0] err_sum;

  assign load = !busy && !q_stat.empty;
  assign pop  = load;
  assign adv  = busy && (!out_valid || m_tready);

  always_comb begin
    // descending lines keep minor_base = start - floor; a nonzero remainder rounds down once more
    minor_cur = descending ? minor_base - COORD_W'(error_term != '0) : minor_base;
    px        = y_major ? minor_cur : major_pos;
    py        = y_major ? major_pos : minor_cur;
    at_end    = (major_pos == major_end);
    err_sum   = {1'b0, error_term} + {1'b0, minor_step};
    wrap      = (major_span != '0) && (err_sum >= {1'b0, major_span});
    error_term_next = wrap ? COORD_W'(err_sum - {1'b0, major_span}) : err_sum[COORD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
      end else if (adv && at_end) begin
        busy <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      major_pos  <= seg.major_start;
      major_end  <= seg.major_end;
      minor_base <= seg.minor_start;
      error_term <= '0;
      minor_step <= seg.minor_step;
      major_span <= seg.major_span;
      y_major    <= seg.y_major;
      descending <= seg.descending;
      ink        <= seg.ink;
    end else if (adv) begin
      major_pos  <= major_pos + 1'b1;
      error_term <= error_term_next;
      if (wrap) begin
        minor_base <= descending ? minor_base - 1'b1 : minor_base + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_x    <= px;
      pixel_y    <= py;
      paint      <= ink;
      in_screen  <= ({1'b0, px} < screen_width) && ({1'b0, py} < screen_height);
      last_pixel <= at_end;
    end
  end

  assign m_tvalid  = out_valid;
  assign m_tdata   = {3'b000, in_screen, paint, pixel_y, pixel_x};
  assign m_tlast   = last_pixel;
  assign stat.busy = busy;

endmodule

FILE: rtl/core/dda_line_rasterizer_top.sv
// An accepted segment passes through the queue and a load step in the pixel stepper
// before its first pixel is registered at the output. A segment of major span N yields
// N + 1 pixels (1 to 64) at one pixel per cycle while m_tready does not stall the output;
// the two-entry queue takes the next segment while the current one is still stepping.
// Reset (synchronous, rst high): queue empty, stepper idle, no output valid,
// screen width and height back to SCREEN_SIZE modulo 128.
module dda_line_rasterizer_top #(
  parameter int SCREEN_SIZE = dlr_pkg::SCREEN_SIZE_DEF,
  parameter int QUEUE_DEPTH = dlr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // start_x[5:0], start_y[11:6], end_x[17:12], end_y[23:18], ink[31:24]
  input  logic [dlr_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // pixel_x[5:0], pixel_y[11:6], paint[19:12], in_screen[20], zero fill[23:21]
  output logic [dlr_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tlast,
  input  logic                           cfg_we,
  input  logic [dlr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dlr_pkg::DIM_W-1:0]      cfg_wdata
);
  import dlr_pkg::*;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(SCREEN_SIZE % (2 ** DIM_W));

  logic [DIM_W-1:0] screen_width, screen_height;
  logic             push, pop;
  seg_t             wr_seg, rd_seg;
  queue_stat_t      q_stat;
  back_stat_t       back_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= DIM_RESET;
      screen_height <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_wdata;
        REG_SCREEN_HEIGHT: screen_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dlr_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_stat   (q_stat),
    .push     (push),
    .seg      (wr_seg)
  );

  dlr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_seg (wr_seg),
    .pop    (pop),
    .rd_seg (rd_seg),
    .stat   (q_stat)
  );

  dlr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .seg           (rd_seg),
    .q_stat        (q_stat),
    .pop           (pop),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .stat          (back_stat)
  );

`ifndef SYNTHESIS
  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  a_stepper_loads: assert property (@(posedge clk) disable iff (rst)
    (!back_stat.busy && !q_stat.empty) |=> back_stat.busy)
    else $error("idle stepper did not take a queued segment");

  a_ends_on_last: assert property (@(posedge clk) disable iff (rst)
    ($fell(back_stat.busy) && !$past(rst)) |-> (m_tvalid && m_tlast))
    else $error("stepper went idle without presenting the last pixel");
`endif

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the DDA line rasterizer: segments in, pixel transactions out.
`timescale 1ns / 1ps

module testbench;
  import dlr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int RANDOM_PHASES = 6;
  localparam int SEGS_PER_PHASE = 26;

  typedef struct packed {
    coord_t           px;
    coord_t           py;
    logic [INK_W-1:0] paint;
    logic             on_screen;
    logic             last;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [DIM_W-1:0]      cfg_wdata = '0;

  logic [IN_DATA_W-1:0] pending_segs[$];
  pixel_t               expected_pixels[$];
  logic [DIM_W-1:0]     screen_w = DIM_W'(SCREEN_SIZE_DEF);
  logic [DIM_W-1:0]     screen_h = DIM_W'(SCREEN_SIZE_DEF);
  logic                 seg_taken = 1'b0;
  int                   error_count = 0;
  int                   burst_left = 0;
  int                   gap_left = 0;
  int                   ready_mode = 0;
  int                   ready_hold = 0;

  dda_line_rasterizer_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Exact DDA: minor = start_minor + floor(k * d_minor / d_major), floor toward -inf.
  task automatic plot_segment(input logic [IN_DATA_W-1:0] seg);
    int sx, sy, ex, ey, smaj, emaj, smin, emin, tmp, span, step, quo, rem, minor;
    bit y_maj, desc;
    pixel_t pix;
    sx = int'(seg[5:0]);
    sy = int'(seg[11:6]);
    ex = int'(seg[17:12]);
    ey = int'(seg[23:18]);
    y_maj = ((sy > ey) ? sy - ey : ey - sy) > ((sx > ex) ? sx - ex : ex - sx);
    if (y_maj) begin
      smaj = sy; emaj = ey; smin = sx; emin = ex;
    end else begin
      smaj = sx; emaj = ex; smin = sy; emin = ey;
    end
    if (smaj > emaj) begin
      tmp = smaj; smaj = emaj; emaj = tmp;
      tmp = smin; smin = emin; emin = tmp;
    end
    span = emaj - smaj;
    desc = emin < smin;
    step = desc ? smin - emin : emin - smin;
    for (int k = 0; k <= span; k++) begin
      minor = smin;
      if (span != 0) begin
        quo = (k * step) / span;
        rem = (k * step) % span;
        minor = desc ? smin - quo - ((rem != 0) ? 1 : 0) : smin + quo;
      end
      pix.px = coord_t'(y_maj ? minor : smaj + k);
      pix.py = coord_t'(y_maj ? smaj + k : minor);
      pix.paint = seg[31:24];
      pix.on_screen = ({1'b0, pix.px} < screen_w) && ({1'b0, pix.py} < screen_h);
      pix.last = (k == span);
      expected_pixels.insert(expected_pixels.size(), pix);
    end
  endtask

  task automatic queue_segment(input logic [IN_DATA_W-1:0] seg);
    pending_segs.insert(pending_segs.size(), seg);
  endtask

  function automatic logic [IN_DATA_W-1:0] pack_segment(int sx, int sy, int ex, int ey, int ink);
    return {INK_W'(ink), coord_t'(ey), coord_t'(ex), coord_t'(sy), coord_t'(sx)};
  endfunction

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : (v > 63) ? 63 : v;
  endfunction

  function automatic logic [IN_DATA_W-1:0] random_segment();
    int sx, sy, d;
    sx = $urandom_range(0, 63);
    sy = $urandom_range(0, 63);
    case ($urandom_range(0, 9))
      0, 1, 2, 3:
        return pack_segment(sx, sy, $urandom_range(0, 63), $urandom_range(0, 63),
                            $urandom_range(0, 255));
      4, 5:
        return pack_segment(sx, sy, clamp_coord(sx + $urandom_range(0, 8) - 4),
                            clamp_coord(sy + $urandom_range(0, 8) - 4), $urandom_range(0, 255));
      6:
        if ($urandom_range(0, 1))
          return pack_segment(sx, sy, $urandom_range(0, 63), sy, $urandom_range(0, 255));
        else
          return pack_segment(sx, sy, sx, $urandom_range(0, 63), $urandom_range(0, 255));
      7: begin
        // near the axis tie (|dy| - |dx| in {-1, 0, 1}) when exactly one y endpoint carries the offset d
        d = $urandom_range(0, 62);
        sx = $urandom_range(0, 63 - d);
        sy = $urandom_range(0, 62 - d);
        return pack_segment(sx, sy + ($urandom_range(0, 1) ? d + $urandom_range(0, 1) : 0),
                            sx + d, sy + $urandom_range(0, 1) + d - d * $urandom_range(0, 1),
                            $urandom_range(0, 255));
      end
      8:
        return pack_segment(sx, sy, sx, sy, $urandom_range(0, 255));
      default:
        return pack_segment(63 * $urandom_range(0, 1), 63 * $urandom_range(0, 1),
                            63 * $urandom_range(0, 1), 63 * $urandom_range(0, 1),
                            $urandom_range(0, 1) ? 255 : 0);
    endcase
  endfunction

  // Output check first, then prediction for a segment taken on the same edge.
  always @(posedge clk) begin
    pixel_t got, want;
    seg_taken <= s_tvalid && s_tready && !rst;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[5:0], m_tdata[11:6], m_tdata[19:12], m_tdata[20], m_tlast};
      if (expected_pixels.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected pixel x=%0d y=%0d paint=%0h in=%0b last=%0b",
                   got.px, got.py, got.paint, got.on_screen, got.last);
      end else begin
        want = expected_pixels.pop_front();
        if (got.px !== want.px || got.py !== want.py || got.paint !== want.paint ||
            got.on_screen !== want.on_screen || got.last !== want.last) begin
          error_count++;
          if (error_count <= 10)
            $display("pixel mismatch: expected x=%0d y=%0d paint=%0h in=%0b last=%0b,",
                     want.px, want.py, want.paint, want.on_screen, want.last,
                     " got x=%0d y=%0d paint=%0h in=%0b last=%0b",
                     got.px, got.py, got.paint, got.on_screen, got.last);
        end
      end
    end
    if (!rst && s_tvalid && s_tready)
      plot_segment(s_tdata);
  end

  // Segment driver: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    logic next_valid;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || seg_taken) begin
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        s_tdata <= $urandom;
      end else if (pending_segs.size() > 0) begin
        s_tdata <= pending_segs.pop_front();
        next_valid = 1'b1;
        if (burst_left > 0)
          burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end
      end
      s_tvalid <= next_valid;
    end
  end

  // Pixel receiver: stall mode is redrawn at random each time ready_hold counts down to zero.
  always @(negedge clk) begin
    if (ready_hold == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_hold <= $urandom_range(20, 80);
    end else begin
      ready_hold <= ready_hold - 1;
    end
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= (ready_hold % 12) < 2;
    endcase
  end

  // Checked at rising edges, where the driver's outputs are settled; returns at a falling edge.
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_segs.size() != 0 || s_tvalid || expected_pixels.size() != 0);
    @(negedge clk);
  endtask

  // Called at a falling edge; the register takes the value on the next rising edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_SCREEN_WIDTH)
      screen_w = value;
    else if (idx == REG_SCREEN_HEIGHT)
      screen_h = value;
  endtask

  initial begin
    logic [DIM_W-1:0] widths[RANDOM_PHASES];
    logic [DIM_W-1:0] heights[RANDOM_PHASES];
    widths = '{7'd0, 7'd1, 7'd64, 7'd63, 7'd1, 7'd127};
    heights = '{7'd127, 7'd1, 7'd64, 7'd32, 7'd1, 7'd0};
    widths[4] = DIM_W'($urandom_range(1, 64));
    heights[4] = DIM_W'($urandom_range(1, 64));
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: degenerate, axis-aligned, diagonal and tie cases, many at the coordinate extremes
    queue_segment(pack_segment(0, 0, 0, 0, 0));
    queue_segment(pack_segment(63, 63, 63, 63, 255));
    queue_segment(pack_segment(0, 0, 63, 0, 8'h41));
    queue_segment(pack_segment(63, 63, 0, 63, 8'hbe));
    queue_segment(pack_segment(0, 0, 0, 63, 8'h5a));
    queue_segment(pack_segment(5, 63, 5, 0, 8'ha5));
    queue_segment(pack_segment(0, 0, 63, 63, 8'h01));
    queue_segment(pack_segment(63, 0, 0, 63, 8'h80));
    queue_segment(pack_segment(0, 5, 63, 9, 8'h2a));
    queue_segment(pack_segment(0, 9, 63, 5, 8'h2b));
    queue_segment(pack_segment(63, 9, 0, 5, 8'h2c));
    queue_segment(pack_segment(10, 0, 0, 63, 8'h7f));
    queue_segment(pack_segment(0, 0, 20, 21, 8'hfe));
    queue_segment(pack_segment(0, 0, 21, 20, 8'h10));
    queue_segment(pack_segment(30, 40, 31, 40, 8'h23));
    queue_segment(pack_segment(31, 40, 30, 41, 8'h24));
    queue_segment(pack_segment(0, 63, 1, 0, 8'hc3));
    queue_segment(pack_segment(63, 0, 62, 63, 8'h3c));
    queue_segment(pack_segment(17, 3, 2, 50, 8'h99));
    queue_segment(pack_segment(42, 42, 42, 43, 8'h66));
    queue_segment(pack_segment(0, 0, 63, 1, 8'hf0));
    queue_segment(pack_segment(63, 62, 0, 63, 8'h0f));

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_drained();
      write_reg(REG_SCREEN_WIDTH, widths[ph]);
      write_reg(REG_SCREEN_HEIGHT, heights[ph]);
      if (ph == 2) begin
        // unmapped indexes must leave both registers alone
        write_reg(REG_SPARE_A, 7'd0);
        write_reg(REG_SPARE_B, 7'h7f);
      end
      for (int i = 0; i < SEGS_PER_PHASE; i++)
        queue_segment(random_segment());
    end

    wait_drained();
    repeat (70) @(negedge clk);
    if (error_count == 0 && expected_pixels.size() == 0)
      $display("** dda_line_rasterizer_top: PASSED **");
    else
      $display("** dda_line_rasterizer_top: FAILED **");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** dda_line_rasterizer_top: FAILED **");
    $finish;
  end

endmodule

FILE: dda_line_rasterizer_top.f
rtl/core/dlr_pkg.sv
rtl/core/dlr_front.sv
rtl/core/dlr_queue.sv
rtl/core/dlr_back.sv
rtl/core/dda_line_rasterizer_top.sv
sim/testbench.sv
